@@ rtl/assert_macros.svh @@
// Assertion macros used by the parser core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MRBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define MRBP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/mrbp_pkg.sv @@
// Shared types, codes and helpers of the management request byte parser.
package mrbp_pkg;

  localparam int unsigned TOKEN_LEN_MAX = 65535;

  localparam logic OP_FEED    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_TOKEN   = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  localparam logic [1:0] TYPE_NONE = 2'd0;
  localparam logic [1:0] TYPE_GET  = 2'd1;
  localparam logic [1:0] TYPE_EDIT = 2'd2;

  localparam logic [7:0] VERSION_BYTE = 8'h01;
  localparam logic [7:0] TOKEN_END    = 8'h00;
  localparam logic [7:0] CMD_MAX      = 8'h08;

  // Edit commands that must carry a zero size high byte.
  localparam logic [3:0] CMD_FIXED_A = 4'd3;
  localparam logic [3:0] CMD_FIXED_B = 4'd4;
  localparam logic [3:0] CMD_FIXED_C = 4'd7;
  localparam logic [3:0] CMD_FIXED_D = 4'd8;

  localparam logic [9:0] SIZE_HI_BIAS = 10'd255;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  byte_kind;
    logic [7:0]  out_byte;
    logic [1:0]  req_type;
    logic [3:0]  command;
    logic [9:0]  payload_len;
    logic [15:0] tok_seen;
  } result_t;

  // Payload length: low byte, plus 255 plus the high byte when it is nonzero.
  function automatic logic [9:0] total_len(input logic [7:0] hi, input logic [7:0] lo);
    logic [9:0] n;
    n = {2'b00, lo};
    if (hi != 8'h00) begin
      n = n + SIZE_HI_BIAS + {2'b00, hi};
    end
    return n;
  endfunction

endpackage

@@ rtl/mgmt_request_byte_parser_core.sv @@
// Top level of the management request byte parser: word registers and handshakes.
//
// Parses a management request one word (byte) at a time: version 0x01, a
// zero-terminated token, type (1 get, 2 edit), command 0..8, size high and
// size low, then the payload. Token and payload bytes are passed out as they
// arrive; every accepted word yields exactly one result word carrying status,
// the passed byte and the parsed header fields. op = 1 restarts the parser.
// Each word goes through an input register, one pass of phase logic and a
// result register; out_valid_o rises when the result register takes it, and
// a new word is taken every cycle unless out_stall_i holds a result back;
// the input register keeps taking words while a finished result waits on
// out_stall_i, if it is itself free. The token count saturates at TokenLenMax.
`include "assert_macros.svh"

module mgmt_request_byte_parser_core #(
  parameter int unsigned TokenLenMax = mrbp_pkg::TOKEN_LEN_MAX
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  byte_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  req_type_o,
  output logic [3:0]  command_o,
  output logic [9:0]  payload_len_o,
  output logic [15:0] tok_seen_o
);
  import mrbp_pkg::*;

  // input word register
  logic       in_valid_q;
  logic       op_q;
  logic [7:0] byte_q;
  // result register
  logic       out_valid_q, out_valid_d;
  result_t    res_q, res_d;

  logic out_ready;  // result register can take a new word this cycle
  logic fire;       // held input word is processed this cycle
  logic in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || fire) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= op_i;
      byte_q <= in_byte_i;
    end
  end

  mrbp_step #(
    .TokenLenMax(TokenLenMax)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .op_i   (op_q),
    .byte_i (byte_q),
    .res_o  (res_d)
  );

  assign out_valid_d = fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign byte_kind_o   = res_q.byte_kind;
  assign out_byte_o    = res_q.out_byte;
  assign req_type_o    = res_q.req_type;
  assign command_o     = res_q.command;
  assign payload_len_o = res_q.payload_len;
  assign tok_seen_o    = res_q.tok_seen;

  // a held word is never dropped while the result side is blocked
  `MRBP_ASSERT(a_hold_in, (in_valid_q && !out_ready) |=> in_valid_q, "input word lost")
  // payload bytes never come with an error status
  `MRBP_NEVER(a_pay_err,
              out_valid_q && res_q.byte_kind == KIND_PAYLOAD && res_q.status == STATUS_ERROR,
              "payload in error")
  // no byte passed means a zero byte field
  `MRBP_ASSERT(a_zero_byte,
               (out_valid_q && res_q.byte_kind == KIND_NONE) |-> res_q.out_byte == 8'h00,
               "stray byte")
  // a processed word always lands in the result register
  `MRBP_ASSERT(a_fire_out, fire |=> out_valid_q, "result not registered")

endmodule

@@ rtl/mrbp_step.sv @@
// Parser phase machine: state registers and the per-word update.
module mrbp_step #(
  parameter int unsigned TokenLenMax = mrbp_pkg::TOKEN_LEN_MAX
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              op_i,
  input  logic [7:0]        byte_i,
  output mrbp_pkg::result_t res_o
);
  import mrbp_pkg::*;

  localparam logic [3:0] PH_VERSION = 4'd0;
  localparam logic [3:0] PH_TOKEN   = 4'd1;
  localparam logic [3:0] PH_TYPE    = 4'd2;
  localparam logic [3:0] PH_CMD     = 4'd3;
  localparam logic [3:0] PH_SIZE_HI = 4'd4;
  localparam logic [3:0] PH_SIZE_LO = 4'd5;
  localparam logic [3:0] PH_DATA    = 4'd6;
  localparam logic [3:0] PH_DONE    = 4'd7;
  localparam logic [3:0] PH_ERROR   = 4'd8;

  localparam logic [15:0] TokMax = 16'(TokenLenMax);

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  type_q, type_d;
  logic [3:0]  cmd_q, cmd_d;
  logic [7:0]  size_hi_q, size_hi_d;
  logic [7:0]  size_lo_q, size_lo_d;
  logic [9:0]  pay_cnt_q, pay_cnt_d;
  logic [15:0] tok_cnt_q, tok_cnt_d;
  logic [1:0]  kind;
  logic [7:0]  obyte;
  logic        hi_forbidden;
  logic [9:0]  len_now;

  always_comb begin
    hi_forbidden = 1'b0;
    if (byte_i != 8'h00) begin
      if (type_q == TYPE_GET) begin
        hi_forbidden = 1'b1;
      end else if (type_q == TYPE_EDIT) begin
        hi_forbidden = cmd_q inside {CMD_FIXED_A, CMD_FIXED_B, CMD_FIXED_C, CMD_FIXED_D};
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    cmd_d     = cmd_q;
    size_hi_d = size_hi_q;
    size_lo_d = size_lo_q;
    pay_cnt_d = pay_cnt_q;
    tok_cnt_d = tok_cnt_q;
    kind      = KIND_NONE;
    obyte     = 8'h00;
    if (op_i == OP_RESTART) begin
      phase_d   = PH_VERSION;
      type_d    = TYPE_NONE;
      cmd_d     = 4'd0;
      size_hi_d = 8'h00;
      size_lo_d = 8'h00;
      pay_cnt_d = 10'd0;
      tok_cnt_d = 16'd0;
    end else begin
      unique case (phase_q)
        PH_VERSION: begin
          phase_d = (byte_i == VERSION_BYTE) ? PH_TOKEN : PH_ERROR;
        end
        PH_TOKEN: begin
          if (byte_i == TOKEN_END) begin
            phase_d = PH_TYPE;
          end else begin
            kind  = KIND_TOKEN;
            obyte = byte_i;
            if (tok_cnt_q < TokMax) begin
              tok_cnt_d = tok_cnt_q + 16'd1;
            end
          end
        end
        PH_TYPE: begin
          if (byte_i == {6'd0, TYPE_GET} || byte_i == {6'd0, TYPE_EDIT}) begin
            type_d  = byte_i[1:0];
            phase_d = PH_CMD;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_CMD: begin
          if (byte_i <= CMD_MAX) begin
            cmd_d   = byte_i[3:0];
            phase_d = PH_SIZE_HI;
          end else begin
            phase_d = PH_ERROR;
          end
        end
        PH_SIZE_HI: begin
          if (hi_forbidden) begin
            phase_d = PH_ERROR;
          end else begin
            size_hi_d = byte_i;
            phase_d   = PH_SIZE_LO;
          end
        end
        PH_SIZE_LO: begin
          size_lo_d = byte_i;
          phase_d   = (total_len(size_hi_q, byte_i) != 10'd0) ? PH_DATA : PH_DONE;
        end
        PH_DATA: begin
          kind      = KIND_PAYLOAD;
          obyte     = byte_i;
          pay_cnt_d = pay_cnt_q + 10'd1;
          if (pay_cnt_d == total_len(size_hi_q, size_lo_q)) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
          // done and error hold until restart
        end
      endcase
    end
  end

  assign len_now = total_len(size_hi_d, size_lo_d);

  always_comb begin
    res_o.status = (phase_d == PH_DONE)  ? STATUS_DONE :
                   (phase_d == PH_ERROR) ? STATUS_ERROR : STATUS_BUSY;
    res_o.byte_kind   = kind;
    res_o.out_byte    = obyte;
    res_o.req_type    = type_d;
    res_o.command     = cmd_d;
    res_o.payload_len = (phase_d == PH_DATA || phase_d == PH_DONE) ? len_now : 10'd0;
    res_o.tok_seen    = tok_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VERSION;
      type_q    <= TYPE_NONE;
      cmd_q     <= 4'd0;
      size_hi_q <= 8'h00;
      size_lo_q <= 8'h00;
      pay_cnt_q <= 10'd0;
      tok_cnt_q <= 16'd0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      type_q    <= type_d;
      cmd_q     <= cmd_d;
      size_hi_q <= size_hi_d;
      size_lo_q <= size_lo_d;
      pay_cnt_q <= pay_cnt_d;
      tok_cnt_q <= tok_cnt_d;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the management request byte parser core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrbp_pkg::*;

  // Run limits.
  localparam int unsigned CYCLE_LIMIT  = 50000;
  localparam int unsigned RANDOM_WORDS = 1200;
  localparam int unsigned BURST_TOKEN_LEN = 180;
  localparam int unsigned SETTLE_CYCLES = 10;   // pipeline is two deep
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned IDLE_PCT     = 31;

  // Parser phases as the predictor tracks them.
  typedef enum logic [3:0] {
    P_VERSION, P_TOKEN, P_TYPE, P_CMD, P_SIZE_HI, P_SIZE_LO, P_DATA, P_DONE, P_ERROR
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = OP_FEED;
  logic [7:0]  in_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [1:0]  byte_kind_o;
  logic [7:0]  out_byte_o;
  logic [1:0]  req_type_o;
  logic [3:0]  command_o;
  logic [9:0]  payload_len_o;
  logic [15:0] tok_seen_o;

  // Predictor state: a private copy of the parser's registers.
  parse_phase_e ph = P_VERSION;
  logic [1:0]   m_type = TYPE_NONE;
  logic [3:0]   m_cmd = 4'd0;
  logic [7:0]   m_hi = 8'h00;
  logic [7:0]   m_lo = 8'h00;
  logic [9:0]   m_pay_cnt = 10'd0;
  logic [15:0]  m_tok_cnt = 16'd0;

  // Expected result words, oldest first.
  result_t expected_results[$];

  bit          idle_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned failures = 0;
  int unsigned requests_done = 0;
  int unsigned requests_failed = 0;
  int unsigned burst_words = 0;

  mgmt_request_byte_parser_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .byte_kind_o  (byte_kind_o),
    .out_byte_o   (out_byte_o),
    .req_type_o   (req_type_o),
    .command_o    (command_o),
    .payload_len_o(payload_len_o),
    .tok_seen_o   (tok_seen_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Payload length from the two size bytes; a nonzero high byte adds 255 + hi.
  function automatic logic [9:0] req_length(input logic [7:0] hi, input logic [7:0] lo);
    logic [9:0] n;
    n = {2'b00, lo};
    if (hi != 8'h00) begin
      n = n + 10'd255 + {2'b00, hi};
    end
    return n;
  endfunction

  // Nonzero size high is only legal for edit commands outside the fixed-size set.
  function automatic bit hi_forbidden(input logic [1:0] ty, input logic [3:0] cmd,
                                      input logic [7:0] hi);
    if (hi == 8'h00) return 1'b0;
    if (ty == TYPE_GET) return 1'b1;
    if (ty == TYPE_EDIT) begin
      return cmd == CMD_FIXED_A || cmd == CMD_FIXED_B ||
             cmd == CMD_FIXED_C || cmd == CMD_FIXED_D;
    end
    return 1'b0;
  endfunction

  // Advances the private parser by one word and returns the result it owes.
  function automatic result_t parse_word(input logic op, input logic [7:0] b);
    result_t      r;
    parse_phase_e prev;
    r = '0;
    prev = ph;
    if (op == OP_RESTART) begin
      ph = P_VERSION;
      m_type = TYPE_NONE;
      m_cmd = 4'd0;
      m_hi = 8'h00;
      m_lo = 8'h00;
      m_pay_cnt = 10'd0;
      m_tok_cnt = 16'd0;
    end else begin
      case (ph)
        P_VERSION: ph = (b == VERSION_BYTE) ? P_TOKEN : P_ERROR;
        P_TOKEN: begin
          if (b == TOKEN_END) begin
            ph = P_TYPE;
          end else begin
            // token bytes stream out; the count sticks at its maximum
            r.byte_kind = KIND_TOKEN;
            r.out_byte = b;
            if (m_tok_cnt < TOKEN_LEN_MAX) m_tok_cnt = m_tok_cnt + 16'd1;
          end
        end
        P_TYPE: begin
          if (b == {6'd0, TYPE_GET} || b == {6'd0, TYPE_EDIT}) begin
            m_type = b[1:0];
            ph = P_CMD;
          end else begin
            ph = P_ERROR;
          end
        end
        P_CMD: begin
          if (b <= CMD_MAX) begin
            m_cmd = b[3:0];
            ph = P_SIZE_HI;
          end else begin
            ph = P_ERROR;
          end
        end
        P_SIZE_HI: begin
          if (hi_forbidden(m_type, m_cmd, b)) begin
            ph = P_ERROR;
          end else begin
            m_hi = b;
            ph = P_SIZE_LO;
          end
        end
        P_SIZE_LO: begin
          m_lo = b;
          // zero length completes right here
          ph = (req_length(m_hi, m_lo) != 10'd0) ? P_DATA : P_DONE;
        end
        P_DATA: begin
          r.byte_kind = KIND_PAYLOAD;
          r.out_byte = b;
          m_pay_cnt = m_pay_cnt + 10'd1;
          if (m_pay_cnt == req_length(m_hi, m_lo)) ph = P_DONE;
        end
        default: ;  // done or error: word ignored until restart
      endcase
    end

    if (ph == P_DONE && prev != P_DONE) requests_done++;
    if (ph == P_ERROR && prev != P_ERROR) requests_failed++;

    r.status = (ph == P_DONE) ? STATUS_DONE : (ph == P_ERROR) ? STATUS_ERROR : STATUS_BUSY;
    r.req_type = m_type;
    r.command = m_cmd;
    r.payload_len = (ph == P_DATA || ph == P_DONE) ? req_length(m_hi, m_lo) : 10'd0;
    r.tok_seen = m_tok_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_failure(input string what, input result_t exp, input result_t act);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("[%0t] %s: exp st=%0d kind=%0d byte=%02h type=%0d cmd=%0d plen=%0d tok=%0d",
               $realtime, what, exp.status, exp.byte_kind, exp.out_byte, exp.req_type,
               exp.command, exp.payload_len, exp.tok_seen);
      $display("    got st=%0d kind=%0d byte=%02h type=%0d cmd=%0d plen=%0d tok=%0d",
               act.status, act.byte_kind, act.out_byte, act.req_type, act.command,
               act.payload_len, act.tok_seen);
    end
  endtask

  // Outputs are sampled at the rising edge before the DUT's own updates land.
  // The result side is handled first so a prediction never races its own result.
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen = {status_o, byte_kind_o, out_byte_o, req_type_o, command_o,
                payload_len_o, tok_seen_o};
        results_checked++;
        if (expected_results.size() == 0) begin
          note_failure("unexpected result word", '0, seen);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) note_failure("result mismatch", want, seen);
        end
      end
      if (in_valid_i && !in_stall_o) expected_results.push_back(parse_word(op_i, in_byte_i));
    end
  end

  // Result side back-pressure, off during the no-idle stretch.
  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Sends one word. Entered and left at a falling edge; valid stays high into
  // the next call unless that call opens a gap, so valid is assigned once per step.
  task automatic send_word(input logic op, input logic [7:0] b);
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    in_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    send_word(OP_FEED, b);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Hand-picked words: restart, bad version, token edges, empty payload,
  // words after completion and error, bad type, bad command, size rule.
  task automatic test_directed_cases();
    send_word(OP_RESTART, 8'hFF);
    feed(8'hFF);                       // bad version
    feed(VERSION_BYTE);                // ignored while in error
    send_word(OP_RESTART, 8'h00);
    feed(VERSION_BYTE);
    feed(8'hFF);
    feed(8'h01);
    feed(TOKEN_END);
    feed({6'd0, TYPE_GET});
    feed(CMD_MAX);
    feed(8'h00);
    feed(8'h00);                       // zero length: done at size low
    feed(8'h3C);                       // ignored after completion
    send_word(OP_RESTART, 8'h5A);
    feed(VERSION_BYTE);
    feed(TOKEN_END);
    feed(8'h00);                       // type zero is rejected
    send_word(OP_RESTART, 8'h00);
    feed(VERSION_BYTE);
    feed(TOKEN_END);
    feed({6'd0, TYPE_EDIT});
    feed(8'h09);                       // one past the last command
    send_word(OP_RESTART, 8'h00);
    feed(VERSION_BYTE);
    feed(TOKEN_END);
    feed({6'd0, TYPE_EDIT});
    feed({4'd0, CMD_FIXED_A});
    feed(8'h01);                       // fixed-size edit with size high set
    drain_results();
  endtask

  // A long token and a short request, sent back to back on both sides.
  task automatic test_token_burst();
    int unsigned start;
    int unsigned i;
    start = words_sent;
    idle_on = 1'b0;
    send_word(OP_RESTART, 8'h00);
    feed(VERSION_BYTE);
    for (i = 0; i < BURST_TOKEN_LEN; i++) feed(8'($urandom_range(255, 1)));
    feed(TOKEN_END);
    feed({6'd0, TYPE_GET});
    feed(8'h02);
    feed(8'h00);
    feed(8'h03);
    for (i = 0; i < 3; i++) feed(8'($urandom_range(255)));
    idle_on = 1'b1;
    drain_results();
    burst_words = words_sent - start;
  endtask

  // One request with random content; some are deliberately broken or cut short.
  task automatic send_request(input bit longest);
    int unsigned n;
    int unsigned i;
    int unsigned roll;
    logic [7:0]  ty;
    logic [7:0]  cmd;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [9:0]  len;

    send_word(OP_RESTART, 8'($urandom_range(255)));

    if (!longest && $urandom_range(99) < 5) begin
      feed(8'($urandom_range(255)));   // probably a bad version
      n = $urandom_range(2);
      for (i = 0; i < n; i++) feed(8'($urandom_range(255)));
      return;
    end
    feed(VERSION_BYTE);

    n = $urandom_range(6);
    for (i = 0; i < n; i++) feed(8'($urandom_range(255, 1)));
    if (!longest && $urandom_range(99) < 3) return;   // abandoned mid-token
    feed(TOKEN_END);

    if (longest) ty = {6'd0, TYPE_EDIT};
    else if ($urandom_range(99) < 90) ty = 8'($urandom_range(2, 1));
    else ty = 8'($urandom_range(255));
    feed(ty);
    if (ty != {6'd0, TYPE_GET} && ty != {6'd0, TYPE_EDIT}) return;

    if (longest) cmd = 8'h00;
    else if ($urandom_range(99) < 90) cmd = 8'($urandom_range(8));
    else cmd = 8'($urandom_range(255, 9));
    feed(cmd);
    if (cmd > CMD_MAX) return;

    roll = $urandom_range(99);
    if (longest) hi = 8'hFF;
    else if (roll < 75) hi = 8'h00;
    else if (roll < 88) hi = 8'($urandom_range(2, 1));
    else hi = 8'($urandom_range(255, 1));
    feed(hi);
    if (hi_forbidden(ty[1:0], cmd[3:0], hi)) return;

    roll = $urandom_range(99);
    if (longest) lo = 8'hFF;
    else if (roll < 60) lo = 8'($urandom_range(8));
    else if (roll < 90) lo = 8'($urandom_range(40));
    else lo = 8'($urandom_range(255));
    feed(lo);

    len = req_length(hi, lo);
    // long payloads are mostly cut short by the next restart
    n = (!longest && len > 10'd64) ? $urandom_range(40, 1) : int'(len);
    for (i = 0; i < n; i++) feed(8'($urandom_range(255)));

    if (n == len && $urandom_range(99) < 20) begin
      n = $urandom_range(3, 1);
      for (i = 0; i < n; i++) feed(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_requests();
    int unsigned start;
    int unsigned reqs;
    start = words_sent;
    reqs = 0;
    send_request(1'b1);                // full 765-byte payload
    drain_results();
    while (words_sent - start < RANDOM_WORDS) begin
      send_request(1'b0);
      reqs++;
      if (reqs % 16 == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_token_burst();
    test_random_requests();

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (expected_results.size() != 0) begin
      failures++;
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("Sent %0d words (%0d in the long-token burst), checked %0d results.",
             words_sent, burst_words, results_checked);
    $display("Requests completed: %0d, rejected: %0d; failures: %0d.",
             requests_done, requests_failed, failures);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
